// ----- rtl/core/llqm_pkg.sv -----
// Package for the linked list queue manager: pool size, field widths,
// request and status codes, and controller state type. No dependencies.
package llqm_pkg;

  localparam int NODES = 16;
  localparam int IDX_W = $clog2(NODES);
  localparam int CNT_W = $clog2(NODES + 1);

  // Fixed widths of the stream fields.
  localparam int OP_W     = 2;
  localparam int NODE_W   = 4;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;
  localparam int HEAD_W   = 4;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SIZE   = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK           = 3'd0,
    STS_EMPTY        = 3'd1,
    STS_NULL         = 3'd2,
    STS_NOT_ISOLATED = 3'd3,
    STS_NOT_FOUND    = 3'd4
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_WB
  } state_t;

endpackage

// ----- rtl/core/llqm_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// Used for the next and prev link tables; no package dependencies.
module llqm_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/linked_list_queue_manager.sv -----
// Linked list queue manager: one circular doubly linked queue over a node pool.
// Depends on llqm_pkg and llqm_ram (next and prev link tables).
//
// Usage: each input beat carries one request (append a node at the tail,
// remove a node, or report the size). Every request produces exactly one
// output beat with a status, the element count after the operation, the head
// index and a head valid flag.
// Timing: when a request is taken, the link tables are read at the node index;
// in the write-back state that follows, the neighbor links are written back
// and the result is loaded into the output register. in_tready is low in the
// write-back state, so a new request is taken only after the write-back.
// out_tvalid rises after the write-back of the request. in_tready is high in
// the cycle after each write-back.
// Stall: while the output register holds an untaken result, a new request is
// still taken, but its write-back waits until the output beat is accepted.
// Reset (rst_n low, synchronous): the queue becomes empty, all linked flags
// clear and any pending result is dropped. The link tables need no clearing:
// an entry is only used for a node that was linked, and so written, before.
module linked_list_queue_manager
  import llqm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata fields from bit 0: node[3:0], zero padding [7:4].
  input  logic [7:0]  in_tdata,
  // in_tuser fields from bit 0: operation[1:0], node_null[2].
  input  logic [2:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata fields from bit 0: status[2:0], count[7:3], head[11:8],
  // zero padding [15:12].
  output logic [15:0] out_tdata,
  // out_tuser fields from bit 0: head_valid[0].
  output logic [0:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready
);

  state_t state_r, state_nxt;

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic             nonempty_r, nonempty_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [NODES-1:0] linked_r;

  // Registered request.
  logic [OP_W-1:0]  req_op_r;
  logic             req_bad_r;
  logic [IDX_W-1:0] req_idx_r;

  // Output register.
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic [HEAD_W-1:0]   out_head_r;
  logic                out_hv_r;

  logic [OP_W-1:0]   in_op;
  logic [NODE_W-1:0] in_node;
  logic              in_null;
  logic [IDX_W-1:0]  in_idx;
  logic              in_bad;
  logic              acc;
  logic              wb_go;
  logic              app_acc;

  logic [IDX_W-1:0] nx, pv;
  status_t          status_c;
  logic             req_linked;
  logic             do_app, do_rem;

  logic             nt_we, pt_we;
  logic [IDX_W-1:0] nt_waddr, pt_waddr;
  logic [IDX_W-1:0] nt_wdata, pt_wdata;

  assign in_node = in_tdata[NODE_W-1:0];
  assign in_op   = in_tuser[OP_W-1:0];
  assign in_null = in_tuser[OP_W];
  assign in_idx  = IDX_W'(in_node);
  // A node outside the pool is handled like a null element.
  assign in_bad  = in_null || (32'(in_node) >= NODES);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_tready = 1'b0;
    wb_go     = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_WB:   wb_go = !out_valid_r || out_tready;
      default: begin
        in_tready = 1'b0;
        wb_go     = 1'b0;
      end
    endcase
  end

  assign acc     = in_tvalid && in_tready;
  assign app_acc = acc && (in_op == OP_APPEND) && !in_bad && !linked_r[in_idx];

  // Request evaluation in the write-back cycle; queue state is still unchanged.
  assign req_linked = linked_r[req_idx_r];

  always_comb begin
    status_c = STS_OK;
    case (req_op_r)
      OP_APPEND: begin
        if (req_bad_r) begin
          status_c = STS_NULL;
        end else if (req_linked) begin
          status_c = STS_NOT_ISOLATED;
        end
      end
      OP_REMOVE: begin
        if (!nonempty_r) begin
          status_c = STS_EMPTY;
        end else if (req_bad_r) begin
          status_c = STS_NULL;
        end else if (!req_linked) begin
          status_c = STS_NOT_FOUND;
        end
      end
      default: status_c = STS_OK;
    endcase
  end

  assign do_app = (req_op_r == OP_APPEND) && (status_c == STS_OK);
  assign do_rem = (req_op_r == OP_REMOVE) && (status_c == STS_OK);

  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    nonempty_nxt = nonempty_r;
    count_nxt    = count_r;
    if (do_app) begin
      tail_nxt     = req_idx_r;
      count_nxt    = count_r + CNT_W'(1);
      nonempty_nxt = 1'b1;
      if (!nonempty_r) begin
        head_nxt = req_idx_r;
      end
    end else if (do_rem) begin
      count_nxt = count_r - CNT_W'(1);
      if (req_idx_r == tail_r) begin
        tail_nxt = pv;
      end
      if (req_idx_r == head_r) begin
        if (nx == req_idx_r) begin
          nonempty_nxt = 1'b0;
          head_nxt     = '0;
        end else begin
          head_nxt = nx;
        end
      end
    end
  end

  // Link table writes. Appends write the new node's own links when the beat is
  // taken, and the neighbors' links at write-back; removes splice at write-back.
  always_comb begin
    nt_we    = 1'b0;
    nt_waddr = req_idx_r;
    nt_wdata = req_idx_r;
    pt_we    = 1'b0;
    pt_waddr = req_idx_r;
    pt_wdata = req_idx_r;
    if (app_acc) begin
      nt_we    = 1'b1;
      nt_waddr = in_idx;
      nt_wdata = nonempty_r ? head_r : in_idx;
      pt_we    = 1'b1;
      pt_waddr = in_idx;
      pt_wdata = nonempty_r ? tail_r : in_idx;
    end else if (wb_go && do_app && nonempty_r) begin
      nt_we    = 1'b1;
      nt_waddr = tail_r;
      nt_wdata = req_idx_r;
      pt_we    = 1'b1;
      pt_waddr = head_r;
      pt_wdata = req_idx_r;
    end else if (wb_go && do_rem) begin
      nt_we    = 1'b1;
      nt_waddr = pv;
      nt_wdata = nx;
      pt_we    = 1'b1;
      pt_waddr = nx;
      pt_wdata = pv;
    end
  end

  llqm_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_next_ram (
    .clk   (clk),
    .we    (nt_we),
    .waddr (nt_waddr),
    .wdata (nt_wdata),
    .re    (acc),
    .raddr (in_idx),
    .rdata (nx)
  );

  llqm_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_prev_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .re    (acc),
    .raddr (in_idx),
    .rdata (pv)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      nonempty_r  <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      linked_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (wb_go) begin
        head_r      <= head_nxt;
        tail_r      <= tail_nxt;
        nonempty_r  <= nonempty_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
        if (do_app) begin
          linked_r[req_idx_r] <= 1'b1;
        end else if (do_rem) begin
          linked_r[req_idx_r] <= 1'b0;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      req_op_r  <= in_op;
      req_bad_r <= in_bad;
      req_idx_r <= in_idx;
    end
    if (wb_go) begin
      out_status_r <= status_c;
      out_count_r  <= COUNT_W'(count_nxt);
      out_head_r   <= nonempty_nxt ? HEAD_W'(head_nxt) : '0;
      out_hv_r     <= nonempty_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_head_r, out_count_r, out_status_r};
  assign out_tuser  = out_hv_r;

`ifndef NO_ASSERTIONS
  a_count_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(linked_r) == 32'(count_r))
    else $error("element count differs from number of linked nodes");

  a_nonempty_count: assert property (@(posedge clk) disable iff (!rst_n)
    nonempty_r == (count_r != '0))
    else $error("non-empty bit disagrees with element count");

  a_head_linked: assert property (@(posedge clk) disable iff (!rst_n)
    nonempty_r |-> linked_r[head_r])
    else $error("head of a non-empty queue is not linked");

  a_wb_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    wb_go |=> out_tvalid)
    else $error("write-back did not present a result beat");
`endif

endmodule
